FILE: rtl/core/pid_controller_clamped_macros.svh
// Assertion macros shared by the controller RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// Check a property on every clock edge out of reset.
`define PIDCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the next cycle.
`define PIDCC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/core/pidcc_pkg.sv
// Package for the clamped PID controller: configuration type, register
// indexes, mode codes, widths and reset values. No dependencies.
package pidcc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned ERR_W     = 33;
  localparam int unsigned VAL_W     = 49;
  localparam int unsigned TERM_W    = 54;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd5;

  localparam logic [1:0] MODE_P   = 2'd0;
  localparam logic [1:0] MODE_PI  = 2'd1;
  localparam logic [1:0] MODE_PID = 2'd2;

  localparam logic signed [31:0] RST_TARGET = 32'sd131072;
  localparam logic [31:0] RST_GAIN_P = 32'd1966080;
  localparam logic [31:0] RST_GAIN_I = 32'd327680;
  localparam logic [31:0] RST_GAIN_D = 32'd0;
  localparam logic [30:0] RST_LIMIT  = 31'd6553600;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] target;
    logic [31:0]        gain_p;
    logic [31:0]        gain_i;
    logic [31:0]        gain_d;
    logic [30:0]        limit;
    logic [1:0]         mode;
  } cfg_t;

endpackage

FILE: rtl/core/pidcc_in_if.sv
// Input channel of the controller: one measured sample per word.
// Depends on nothing.
interface pidcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured;

  modport source (output valid, output measured, input ready);
  modport sink (input valid, input measured, output ready);
endinterface

FILE: rtl/core/pidcc_out_if.sv
// Result channel of the controller: drive value and clamp flag per word.
// Depends on nothing.
interface pidcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               clamped;

  modport source (output valid, output drive, output clamped, input ready);
  modport sink (input valid, input drive, input clamped, output ready);
endinterface

FILE: rtl/core/pidcc_cfg_if.sv
// Configuration write channel: register index and write data per word.
// Depends on pidcc_pkg for the index width.
interface pidcc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pidcc_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/pidcc_regs.sv
// Configuration register file of the controller.
// Depends on pidcc_pkg and pidcc_cfg_if.
module pidcc_regs (
  input  logic              clk,
  input  logic              rst_n,
  pidcc_cfg_if.sink         cfg_if,
  output pidcc_pkg::cfg_t   cfg_r
);

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= pidcc_pkg::RST_TARGET;
      cfg_r.gain_p <= pidcc_pkg::RST_GAIN_P;
      cfg_r.gain_i <= pidcc_pkg::RST_GAIN_I;
      cfg_r.gain_d <= pidcc_pkg::RST_GAIN_D;
      cfg_r.limit  <= pidcc_pkg::RST_LIMIT;
      cfg_r.mode   <= pidcc_pkg::MODE_PID;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        pidcc_pkg::REG_TARGET: cfg_r.target <= $signed(cfg_if.data);
        pidcc_pkg::REG_GAIN_P: cfg_r.gain_p <= cfg_if.data;
        pidcc_pkg::REG_GAIN_I: cfg_r.gain_i <= cfg_if.data;
        pidcc_pkg::REG_GAIN_D: cfg_r.gain_d <= cfg_if.data;
        pidcc_pkg::REG_LIMIT:  cfg_r.limit  <= cfg_if.data[30:0];
        pidcc_pkg::REG_MODE:   cfg_r.mode   <= cfg_if.data[1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/pidcc_integ.sv
// Error stage: forms the error, updates the saturated error sum (limited in
// PID mode) and the previous error, and registers the three term operands.
// Depends on pidcc_pkg.
module pidcc_integ (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  logic                                   upd,
  input  logic signed [31:0]                     measured,
  input  pidcc_pkg::cfg_t                        cfg,
  output logic signed [pidcc_pkg::VAL_W-1:0]     v_p_r,
  output logic signed [pidcc_pkg::VAL_W-1:0]     v_i_r,
  output logic signed [pidcc_pkg::VAL_W-1:0]     v_d_r,
  output logic                                   flag_r,
  output logic signed [pidcc_pkg::SUM_W-1:0]     error_sum_r
);

  logic signed [pidcc_pkg::ERR_W-1:0]   prev_err_r;
  logic signed [pidcc_pkg::ERR_W-1:0]   err;
  logic signed [pidcc_pkg::ERR_W:0]     diff;
  logic signed [pidcc_pkg::SUM_W:0]     s_wide;
  logic signed [pidcc_pkg::SUM_W-1:0]   s_sat;
  logic signed [pidcc_pkg::SUM_W-1:0]   lim;
  logic signed [pidcc_pkg::SUM_W-1:0]   error_sum_nxt;
  logic signed [pidcc_pkg::VAL_W-1:0]   v_p_nxt;
  logic signed [pidcc_pkg::VAL_W-1:0]   v_i_nxt;
  logic signed [pidcc_pkg::VAL_W-1:0]   v_d_nxt;
  logic                                 flag_nxt;
  logic                                 ovf;
  logic                                 clip;
  logic                                 acc;
  logic                                 pid;

  always_comb begin
    acc  = (cfg.mode != pidcc_pkg::MODE_P);
    pid  = acc && (cfg.mode != pidcc_pkg::MODE_PI);
    err  = $signed({cfg.target[31], cfg.target}) - $signed({measured[31], measured});
    diff = $signed({err[32], err}) - $signed({prev_err_r[32], prev_err_r});

    s_wide = $signed({error_sum_r[47], error_sum_r}) + $signed({{16{err[32]}}, err});
    ovf    = s_wide[48] ^ s_wide[47];
    if (ovf) begin
      s_sat = s_wide[48] ? pidcc_pkg::SUM_MIN : pidcc_pkg::SUM_MAX;
    end else begin
      s_sat = s_wide[47:0];
    end

    lim  = $signed({17'd0, cfg.limit});
    clip = 1'b0;
    error_sum_nxt = s_sat;
    if (pid && (s_sat > lim)) begin
      error_sum_nxt = lim;
      clip = 1'b1;
    end else if (pid && (s_sat < -lim)) begin
      error_sum_nxt = -lim;
      clip = 1'b1;
    end

    flag_nxt = acc && (ovf || clip);
    v_p_nxt  = $signed({{16{err[32]}}, err});
    v_i_nxt  = acc ? $signed({error_sum_nxt[47], error_sum_nxt}) : '0;
    v_d_nxt  = pid ? $signed({{15{diff[33]}}, diff}) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      prev_err_r  <= '0;
    end else if (upd) begin
      if (acc) begin
        error_sum_r <= error_sum_nxt;
      end
      if (pid) begin
        prev_err_r <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      v_p_r  <= v_p_nxt;
      v_i_r  <= v_i_nxt;
      v_d_r  <= v_d_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

FILE: rtl/core/pidcc_scale.sv
// Q16.16 scaling of one signed operand by an unsigned gain: two registered
// partial products, then floor shift by 16 and limit to +-2^52.
// Depends on pidcc_pkg.
module pidcc_scale (
  input  logic                                  clk,
  input  logic                                  ld_prod,
  input  logic                                  ld_term,
  input  logic signed [pidcc_pkg::VAL_W-1:0]    v,
  input  logic [31:0]                           gain,
  output logic signed [pidcc_pkg::TERM_W-1:0]   term_r
);

  localparam logic signed [66:0] TERM_MAX = 67'sh10_0000_0000_0000;
  localparam logic signed [66:0] TERM_MIN = -TERM_MAX;

  logic signed [57:0] ph_r;
  logic signed [57:0] ph_nxt;
  logic [55:0]        pl_r;
  logic [55:0]        pl_nxt;
  logic signed [66:0] t;
  logic signed [pidcc_pkg::TERM_W-1:0] term_nxt;

  always_comb begin
    ph_nxt = $signed({{33{v[48]}}, v[48:24]}) * $signed({26'd0, gain});
    pl_nxt = {32'd0, v[23:0]} * {24'd0, gain};
  end

  always_comb begin
    t = $signed({ph_r[57], ph_r, 8'd0}) + $signed({27'd0, pl_r[55:16]});
    if (t > TERM_MAX) begin
      term_nxt = TERM_MAX[53:0];
    end else if (t < TERM_MIN) begin
      term_nxt = TERM_MIN[53:0];
    end else begin
      term_nxt = t[53:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_prod) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
    if (ld_term) begin
      term_r <= term_nxt;
    end
  end

endmodule

FILE: rtl/core/pid_controller_clamped.sv
// Clamped positional PID controller, top level: register file, error stage,
// three scaling units and the saturating output stage.
// Depends on pidcc_pkg, the channel interfaces, pidcc_regs, pidcc_integ,
// pidcc_scale and pid_controller_clamped_macros.svh.
//
// One measured sample per word in, one drive word out. The pipeline takes a
// new sample every cycle while the output is not stalled and passes it through
// the input register, error stage, partial products, term limit, output sum.
// The error sum and previous error update in the error stage, which sets the
// sustained rate of one sample per cycle. Each stage holds only while the next
// is full and held, so a stalled output still lets the earlier stages fill.
// cfg_ready is always high; write registers only while no sample is in flight.
`include "pid_controller_clamped_macros.svh"

module pid_controller_clamped (
  input  logic          clk,
  input  logic          rst_n,
  pidcc_in_if.sink      in_if,
  pidcc_out_if.source   out_if,
  pidcc_cfg_if.sink     cfg_if
);

  pidcc_pkg::cfg_t cfg;

  logic va_r, vb_r, vc_r, vd_r, out_valid_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic flag_b, flag_c_r, flag_d_r;
  logic signed [31:0] meas_r;
  logic signed [pidcc_pkg::VAL_W-1:0]  v_p, v_i, v_d;
  logic signed [pidcc_pkg::TERM_W-1:0] term_p, term_i, term_d;
  logic signed [pidcc_pkg::SUM_W-1:0]  error_sum;
  logic signed [pidcc_pkg::SUM_W-1:0]  lim_ext;
  logic signed [55:0] total;
  logic [24:0]        total_hi;
  logic               sat;
  logic signed [31:0] drive_nxt;
  logic signed [31:0] drive_r;
  logic               clamped_r;
  logic               upd;
  logic               pid_mode;

  assign rdy_e = !out_valid_r || out_if.ready;
  assign rdy_d = !vd_r || rdy_e;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;
  assign upd   = va_r && rdy_b;

  assign in_if.ready    = rdy_a;
  assign out_if.valid   = out_valid_r;
  assign out_if.drive   = drive_r;
  assign out_if.clamped = clamped_r;

  pidcc_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg_r  (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_if.valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_e) out_valid_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) meas_r <= in_if.measured;
    if (rdy_c) flag_c_r <= flag_b;
    if (rdy_d) flag_d_r <= flag_c_r;
    if (rdy_e) begin
      drive_r   <= drive_nxt;
      clamped_r <= flag_d_r || sat;
    end
  end

  pidcc_integ u_integ (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (rdy_b),
    .upd         (upd),
    .measured    (meas_r),
    .cfg         (cfg),
    .v_p_r       (v_p),
    .v_i_r       (v_i),
    .v_d_r       (v_d),
    .flag_r      (flag_b),
    .error_sum_r (error_sum)
  );

  pidcc_scale u_scale_p (
    .clk     (clk),
    .ld_prod (rdy_c),
    .ld_term (rdy_d),
    .v       (v_p),
    .gain    (cfg.gain_p),
    .term_r  (term_p)
  );

  pidcc_scale u_scale_i (
    .clk     (clk),
    .ld_prod (rdy_c),
    .ld_term (rdy_d),
    .v       (v_i),
    .gain    (cfg.gain_i),
    .term_r  (term_i)
  );

  pidcc_scale u_scale_d (
    .clk     (clk),
    .ld_prod (rdy_c),
    .ld_term (rdy_d),
    .v       (v_d),
    .gain    (cfg.gain_d),
    .term_r  (term_d)
  );

  always_comb begin
    total = $signed({{2{term_p[53]}}, term_p}) + $signed({{2{term_i[53]}}, term_i})
          + $signed({{2{term_d[53]}}, term_d});
    total_hi = total[55:31];
    sat = !((&total_hi) || !(|total_hi));
    if (sat) begin
      drive_nxt = total[55] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      drive_nxt = total[31:0];
    end
  end

  assign pid_mode = (cfg.mode != pidcc_pkg::MODE_P) && (cfg.mode != pidcc_pkg::MODE_PI);
  assign lim_ext  = $signed({17'd0, cfg.limit});

  `PIDCC_ASSERT(a_full_when_blocked, !in_if.ready |-> (va_r && vb_r && vc_r && vd_r && out_valid_r), "input blocked with a free stage")
  `PIDCC_ASSERT_NEXT(a_sum_p_hold, upd && (cfg.mode == pidcc_pkg::MODE_P), $stable(error_sum), "error sum moved in P mode")
  `PIDCC_ASSERT_NEXT(a_sum_in_limit, upd && pid_mode, (error_sum <= lim_ext) && (error_sum >= -lim_ext), "error sum outside limit in PID mode")

endmodule
